[rtl/kms_pkg.sv]
// kms_pkg: shared types and constants of the key matrix scanner
// holds defaults, phase encoding, encoder patterns and the per-step control struct
// no dependencies

package kms_pkg;

  // parameter defaults
  localparam int unsigned RowCountDef  = 5;
  localparam int unsigned CountBitsDef = 16;

  // row index and line select widths
  localparam int unsigned RowIdxW = 3;
  localparam int unsigned SelW    = 3;

  // line select code for the encoder strobe
  localparam logic [SelW-1:0] EncSelect = 3'd5;

  // mode codes
  localparam logic ModeScan  = 1'b0;
  localparam logic ModeClear = 1'b1;

  // encoder history patterns
  localparam logic [3:0] PatRight = 4'b1011;
  localparam logic [3:0] PatLeft  = 4'b0111;

  // scan phase, one-hot
  typedef enum logic [1:0] {
    PH_KEY = 2'b01,
    PH_ENC = 2'b10
  } phase_e;

  // what one step does to the state
  typedef struct packed {
    logic key_tick;
    logic enc_tick;
    logic clear;
  } step_ctrl_t;

endpackage

[rtl/kms_key_scan.sv]
// kms_key_scan: key level word, press/release latches, aux flag and row counter
// depends on kms_pkg

module kms_key_scan #(
  parameter int unsigned ROW_COUNT = kms_pkg::RowCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kms_pkg::step_ctrl_t         ctrl_i,
  input  logic [3:0]                  sense_i,
  input  logic                        aux_i,
  output logic [kms_pkg::RowIdxW-1:0] row_o,
  output logic [4*ROW_COUNT-1:0]      key_state_o,
  output logic [4*ROW_COUNT-1:0]      pressed_o,
  output logic [4*ROW_COUNT-1:0]      released_o,
  output logic                        aux_seen_o
);

  localparam int unsigned KeyW = 4 * ROW_COUNT;
  localparam logic [kms_pkg::RowIdxW-1:0] LastRow = kms_pkg::RowIdxW'(ROW_COUNT - 1);

  logic [kms_pkg::RowIdxW-1:0] row_q, row_d;
  logic [KeyW-1:0]             keys_q, keys_d, keys_new;
  logic [KeyW-1:0]             press_q, press_d;
  logic [KeyW-1:0]             rel_q, rel_d;
  logic                        aux_q, aux_d;
  logic [3:0]                  nib;

  // sense bits reversed into the nibble
  assign nib = {sense_i[0], sense_i[1], sense_i[2], sense_i[3]};

  for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
    assign keys_new[4*r +: 4] = (row_q == kms_pkg::RowIdxW'(r)) ? nib : keys_q[4*r +: 4];
  end

  always_comb begin
    row_d   = row_q;
    keys_d  = keys_q;
    press_d = press_q;
    rel_d   = rel_q;
    aux_d   = aux_q;
    if (ctrl_i.clear) begin
      press_d = '0;
      rel_d   = '0;
      aux_d   = 1'b0;
    end else if (ctrl_i.key_tick) begin
      keys_d  = keys_new;
      press_d = press_q | (keys_new & ~keys_q);
      rel_d   = rel_q | (keys_q & ~keys_new);
      aux_d   = aux_q | aux_i;
      row_d   = (row_q == LastRow) ? '0 : row_q + kms_pkg::RowIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      keys_q  <= '0;
      press_q <= '0;
      rel_q   <= '0;
      aux_q   <= 1'b0;
    end else begin
      row_q   <= row_d;
      keys_q  <= keys_d;
      press_q <= press_d;
      rel_q   <= rel_d;
      aux_q   <= aux_d;
    end
  end

  assign row_o       = row_q;
  assign key_state_o = keys_q;
  assign pressed_o   = press_q;
  assign released_o  = rel_q;
  assign aux_seen_o  = aux_q;

endmodule

[rtl/kms_enc_decode.sv]
// kms_enc_decode: quadrature history and wrapping left/right step counters
// depends on kms_pkg

module kms_enc_decode #(
  parameter int unsigned COUNT_BITS = kms_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kms_pkg::step_ctrl_t   ctrl_i,
  input  logic [1:0]            enc_i,
  output logic [COUNT_BITS-1:0] right_o,
  output logic [COUNT_BITS-1:0] left_o
);

  logic [3:0]            hist_q, hist_d, hist_new;
  logic [COUNT_BITS-1:0] right_q, right_d;
  logic [COUNT_BITS-1:0] left_q, left_d;

  assign hist_new = {hist_q[1:0], enc_i};

  always_comb begin
    hist_d  = hist_q;
    right_d = right_q;
    left_d  = left_q;
    if (ctrl_i.clear) begin
      right_d = '0;
      left_d  = '0;
    end else if (ctrl_i.enc_tick) begin
      hist_d = hist_new;
      if (hist_new == kms_pkg::PatRight) right_d = right_q + COUNT_BITS'(1);
      if (hist_new == kms_pkg::PatLeft)  left_d  = left_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      right_q <= '0;
      left_q  <= '0;
    end else begin
      hist_q  <= hist_d;
      right_q <= right_d;
      left_q  <= left_d;
    end
  end

  assign right_o = right_q;
  assign left_o  = left_q;

endmodule

[rtl/key_matrix_scan_with_encoder.sv]
// key_matrix_scan_with_encoder: top level of the key matrix scanner
// depends on kms_pkg, kms_key_scan, kms_enc_decode
//
// usage
// - input channel (in_valid_i/in_ready_o) carries one request per scan tick:
//   mode_i (scan or clear), sense_raw_i and aux_button_i
// - scan requests alternate between a key phase (sample the driven row) and an
//   encoder phase (shift sense bits 3:2 into the quadrature history)
// - a clear request empties the event latches, aux flag and both counters,
//   leaving phase, row, key levels and encoder history alone
// - output channel (out_valid_o/out_ready_i) gives the full state after each
//   request; next_select_o is the line to drive for the next tick
// - a request accepted goes through the input register, then into the state and
//   result registers; throughput is one request per cycle while out_ready_i holds,
//   the state update is a single level of bit logic plus one counter increment
// - an input register and the state/result registers part the two sides, so
//   a new request is taken while a finished result still waits
// - when the receiver stalls, the result holds and one more request waits in
//   the input register; in_ready_o drops only then
// - reset clears all state: key phase, row 0, all words and counters zero

module key_matrix_scan_with_encoder #(
  parameter int unsigned ROW_COUNT  = kms_pkg::RowCountDef,
  parameter int unsigned COUNT_BITS = kms_pkg::CountBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [3:0]                sense_raw_i,
  input  logic                      aux_button_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [4*ROW_COUNT-1:0]    key_state_o,
  output logic [4*ROW_COUNT-1:0]    pressed_events_o,
  output logic [4*ROW_COUNT-1:0]    released_events_o,
  output logic                      aux_seen_o,
  output logic [COUNT_BITS-1:0]     right_count_o,
  output logic [COUNT_BITS-1:0]     left_count_o,
  output logic [kms_pkg::SelW-1:0]  next_select_o
);

  // input register
  logic       req_valid_q, req_valid_d;
  logic       mode_q;
  logic [3:0] sense_q;
  logic       aux_q;

  // result valid and phase
  logic            res_valid_q, res_valid_d;
  kms_pkg::phase_e phase_q, phase_d;

  logic                        accept;
  logic                        advance;
  kms_pkg::step_ctrl_t         ctrl;
  logic [kms_pkg::RowIdxW-1:0] row;

  // a held request moves into the state when the result slot is free
  assign advance    = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign req_valid_d = accept ? 1'b1 : (advance ? 1'b0 : req_valid_q);
  assign res_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : res_valid_q);

  // step decode: clear, or the scan phase that is due
  always_comb begin
    ctrl    = '0;
    phase_d = phase_q;
    if (advance) begin
      if (mode_q == kms_pkg::ModeClear) begin
        ctrl.clear = 1'b1;
      end else begin
        unique case (phase_q)
          kms_pkg::PH_KEY: begin
            ctrl.key_tick = 1'b1;
            phase_d       = kms_pkg::PH_ENC;
          end
          kms_pkg::PH_ENC: begin
            ctrl.enc_tick = 1'b1;
            phase_d       = kms_pkg::PH_KEY;
          end
          default: begin
            phase_d = kms_pkg::PH_KEY;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      phase_q     <= kms_pkg::PH_KEY;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
      phase_q     <= phase_d;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      sense_q <= sense_raw_i;
      aux_q   <= aux_button_i;
    end
  end

  // key phase logic; its state registers are the result registers
  kms_key_scan #(
    .ROW_COUNT (ROW_COUNT)
  ) u_key_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sense_i     (sense_q),
    .aux_i       (aux_q),
    .row_o       (row),
    .key_state_o (key_state_o),
    .pressed_o   (pressed_events_o),
    .released_o  (released_events_o),
    .aux_seen_o  (aux_seen_o)
  );

  // encoder phase logic: sense bit 3 is the new history bit 0, bit 2 is bit 1
  kms_enc_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_enc_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .enc_i   ({sense_q[2], sense_q[3]}),
    .right_o (right_count_o),
    .left_o  (left_count_o)
  );

  assign out_valid_o   = res_valid_q;
  // row to drive in the key phase, encoder strobe otherwise
  assign next_select_o = (phase_q == kms_pkg::PH_KEY) ? kms_pkg::SelW'(row) : kms_pkg::EncSelect;

endmodule
